FILE: hw/rtl/ptb_pkg.sv
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types and constants of the periodic timer bank.
// ----------------------------------------------------------------------------
`default_nettype none

package ptb_pkg;

  localparam int          SLOTS_DEF      = 16;
  localparam int          MAX_SLOTS      = 16;
  localparam int          VAL_W          = 16;
  localparam int          SLOT_W         = 4;
  localparam int          FIRED_W        = 5;
  localparam logic [15:0] PRESCALE_RESET = 16'd1000;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_CREATE = 2'd1,
    FUNC_DELETE = 2'd2,
    FUNC_SCAN   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOT_USE = 2'd2,
    ST_NONE    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_FIRED,
    S_SCAN
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic sweep_step;
    logic fired_emit;
    logic scan_emit;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic period_due;
    logic pend_any;
    logic scan_last;
    logic sweep_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ptb_in_if.sv
// ----------------------------------------------------------------------------
// ptb_in_if
// Request channel of the timer bank: valid/ready with the request payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] interval;
  logic [15:0] repeats;
  logic        forever_req;
  logic [3:0]  slot;

  modport source (output valid, func, interval, repeats, forever_req, slot, input ready);
  modport sink   (input valid, func, interval, repeats, forever_req, slot, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ptb_out_if.sv
// ----------------------------------------------------------------------------
// ptb_out_if
// Result channel of the timer bank: valid/ready with the result payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] slot_out;
  logic [4:0] fired_count;
  logic       last;

  modport source (output valid, status, slot_out, fired_count, last, input ready);
  modport sink   (input valid, status, slot_out, fired_count, last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ptb_ctrl.sv
// ----------------------------------------------------------------------------
// ptb_ctrl
// Sequencer of the timer bank: request intake, period sweep, pending scan.
// ----------------------------------------------------------------------------
`default_nettype none

module ptb_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire  [1:0]          in_func,
  output logic                in_ready,
  input  ptb_pkg::dp_stat_t   stat,
  output ptb_pkg::ctl_cmd_t   cmd
);
  import ptb_pkg::*;

  state_t state_r;
  state_t state_nxt;
  func_t  func;

  assign func = func_t'(in_func);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = stat.out_free;
        if (in_valid && stat.out_free) begin
          cmd.accept = 1'b1;
          if (func == FUNC_TICK && stat.period_due) begin
            state_nxt = S_SWEEP;
          end else if (func == FUNC_SCAN && stat.pend_any) begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_FIRED;
        end
      end
      S_FIRED: begin
        if (stat.out_free) begin
          cmd.fired_emit = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat.out_free) begin
          cmd.scan_emit = 1'b1;
          if (stat.scan_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ptb_datapath.sv
// ----------------------------------------------------------------------------
// ptb_datapath
// Slot state, prescaler, one-slot-per-cycle period update and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptb_datapath #(
  parameter int SLOTS = ptb_pkg::SLOTS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_wr_en,
  input  wire  [15:0]         cfg_wr_data,
  input  wire  [1:0]          in_func,
  input  wire  [15:0]         in_interval,
  input  wire  [15:0]         in_repeats,
  input  wire                 in_forever_req,
  input  wire  [3:0]          in_slot,
  input  ptb_pkg::ctl_cmd_t   cmd,
  output ptb_pkg::dp_stat_t   stat,
  input  wire                 out_ready,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [3:0]          out_slot_out,
  output logic [4:0]          out_fired_count,
  output logic                out_last
);
  import ptb_pkg::*;

  localparam int NSLOT = (SLOTS < MAX_SLOTS) ? SLOTS : MAX_SLOTS;
  localparam int IDX_W = (NSLOT > 1) ? $clog2(NSLOT) : 1;

  logic [15:0]      prescale_r;
  logic [15:0]      base_count_r;
  logic [NSLOT-1:0] in_use_r;
  logic [NSLOT-1:0] pending_r;
  logic [15:0]      period_len_r [NSLOT];
  logic [15:0]      elapsed_r    [NSLOT];
  logic [15:0]      remaining_r  [NSLOT];
  logic             endless_r    [NSLOT];
  logic [IDX_W-1:0] idx_r;
  logic [4:0]       fired_r;
  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [3:0]       out_slot_r;
  logic [4:0]       out_fired_r;
  logic             out_last_r;

  func_t            func;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [NSLOT-1:0] pend_vec;
  logic [IDX_W-1:0] pend_idx;
  logic [NSLOT-1:0] pend_rest;
  logic             del_ok;
  logic [IDX_W-1:0] del_idx;
  logic             live;
  logic [15:0]      el_inc;
  logic             hit;
  logic             out_free;

  logic             emit;
  status_t          emit_status;
  logic [3:0]       emit_slot;
  logic [4:0]       emit_fired;
  logic             emit_last;

  assign func     = func_t'(in_func);
  assign out_free = !out_valid_r || out_ready;
  assign pend_vec = in_use_r & pending_r;
  assign del_idx  = in_slot[IDX_W-1:0];
  assign del_ok   = ({1'b0, in_slot} < 5'(NSLOT)) && in_use_r[del_idx];

  // lowest free slot and lowest pending slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    pend_idx   = '0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
      if (pend_vec[i]) begin
        pend_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    pend_rest           = pend_vec;
    pend_rest[pend_idx] = 1'b0;
  end

  // period update of the slot under the sweep index
  assign live   = in_use_r[idx_r] && !pending_r[idx_r]
                  && (endless_r[idx_r] || remaining_r[idx_r] != 16'd0);
  assign el_inc = (elapsed_r[idx_r] == 16'hFFFF) ? elapsed_r[idx_r]
                                                 : elapsed_r[idx_r] + 16'd1;
  assign hit    = el_inc >= period_len_r[idx_r];

  always_comb begin
    stat.period_due = base_count_r >= prescale_r;
    stat.pend_any   = |pend_vec;
    stat.scan_last  = ~|pend_rest;
    stat.sweep_last = idx_r == IDX_W'(NSLOT - 1);
    stat.out_free   = out_free;
  end

  // result selection
  always_comb begin
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_slot   = '0;
    emit_fired  = '0;
    emit_last   = 1'b1;
    if (cmd.accept) begin
      unique case (func)
        FUNC_TICK: begin
          emit = !stat.period_due;
        end
        FUNC_CREATE: begin
          emit = 1'b1;
          if (free_found) begin
            emit_slot = 4'(free_idx);
          end else begin
            emit_status = ST_FULL;
          end
        end
        FUNC_DELETE: begin
          emit = 1'b1;
          if (del_ok) begin
            emit_slot = in_slot;
          end else begin
            emit_status = ST_NOT_USE;
          end
        end
        FUNC_SCAN: begin
          emit        = !stat.pend_any;
          emit_status = ST_NONE;
        end
        default: emit = 1'b0;
      endcase
    end else if (cmd.fired_emit) begin
      emit       = 1'b1;
      emit_fired = fired_r;
    end else if (cmd.scan_emit) begin
      emit      = 1'b1;
      emit_slot = 4'(pend_idx);
      emit_last = stat.scan_last;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r   <= PRESCALE_RESET;
      base_count_r <= '0;
      in_use_r     <= '0;
      pending_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        prescale_r <= cfg_wr_data;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.accept) begin
        unique case (func)
          FUNC_TICK: begin
            base_count_r <= stat.period_due ? 16'd1 : base_count_r + 16'd1;
          end
          FUNC_CREATE: begin
            if (free_found) begin
              in_use_r[free_idx]  <= 1'b1;
              pending_r[free_idx] <= 1'b0;
            end
          end
          FUNC_DELETE: begin
            if (del_ok) begin
              in_use_r[del_idx]  <= 1'b0;
              pending_r[del_idx] <= 1'b0;
            end
          end
          default: ;
        endcase
      end
      if (cmd.sweep_step && live && hit) begin
        pending_r[idx_r] <= 1'b1;
      end
      if (cmd.scan_emit) begin
        pending_r[pend_idx] <= 1'b0;
      end
    end
  end

  // slot payload, sweep counters and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept && func == FUNC_TICK) begin
      idx_r   <= '0;
      fired_r <= '0;
    end
    if (cmd.accept && func == FUNC_CREATE && free_found) begin
      period_len_r[free_idx] <= in_interval;
      elapsed_r[free_idx]    <= '0;
      remaining_r[free_idx]  <= in_repeats;
      endless_r[free_idx]    <= in_forever_req;
    end
    if (cmd.sweep_step) begin
      idx_r <= idx_r + IDX_W'(1);
      if (live) begin
        if (hit) begin
          elapsed_r[idx_r] <= '0;
          fired_r          <= fired_r + 5'd1;
          if (!endless_r[idx_r]) begin
            remaining_r[idx_r] <= remaining_r[idx_r] - 16'd1;
          end
        end else begin
          elapsed_r[idx_r] <= el_inc;
        end
      end
    end
    if (emit) begin
      out_status_r <= emit_status;
      out_slot_r   <= emit_slot;
      out_fired_r  <= emit_fired;
      out_last_r   <= emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot_out    = out_slot_r;
  assign out_fired_count = out_fired_r;
  assign out_last        = out_last_r;

endmodule

`default_nettype wire

FILE: hw/rtl/periodic_timer_bank.sv
// ----------------------------------------------------------------------------
// periodic_timer_bank
// Bank of repeating timer slots behind a base-tick prescaler.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  in_chan   in   valid / ready    func, interval, repeats, forever_req, slot
//  out_chan  out  valid / ready    status, slot_out, fired_count, last
//  cfg_*     in   write enable     prescale (16 bit)
//
//  Create, delete and a tick that runs no period give one result beat each.
//  A tick that runs a period sweeps the min(SLOTS,16) slots one per cycle.
//  A scan gives one result beat per pending slot, one per cycle unless stalled.
//  Reset clears the in-use and pending bits at once; no clearing pass.
//  A stalled result holds the register and the next request waits.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_timer_bank #(
  parameter int SLOTS = ptb_pkg::SLOTS_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        cfg_wr_en,
  input  wire [15:0] cfg_wr_data,
  ptb_in_if.sink     in_chan,
  ptb_out_if.source  out_chan
);
  import ptb_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  ptb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_func  (in_chan.func),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ptb_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_func         (in_chan.func),
    .in_interval     (in_chan.interval),
    .in_repeats      (in_chan.repeats),
    .in_forever_req  (in_chan.forever_req),
    .in_slot         (in_chan.slot),
    .cmd             (cmd),
    .stat            (stat),
    .out_ready       (out_chan.ready),
    .out_valid       (out_chan.valid),
    .out_status      (out_chan.status),
    .out_slot_out    (out_chan.slot_out),
    .out_fired_count (out_chan.fired_count),
    .out_last        (out_chan.last)
  );

endmodule

`default_nettype wire
